>>> rtl/imu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_pkg
// Shared types and constants of the ISO 8583 message unpacker.
// ----------------------------------------------------------------------------
package imu_pkg;

  localparam int NumFields       = 128;
  localparam int MaxFieldLen     = 30000;
  localparam int MaxPrefixDigits = 20;
  localparam int HeaderBytes     = 4 + 16;
  localparam int FieldAw         = $clog2(NumFields);
  localparam int DefW            = 20;

  typedef enum logic [0:0] {
    OP_DEFINE = 1'b0,
    OP_BYTE   = 1'b1
  } imu_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_OVER_LEN  = 3'd3,
    ST_BAD_DIGIT = 3'd4
  } imu_status_t;

  typedef enum logic [2:0] {
    PH_MTI,
    PH_BITMAP,
    PH_PREFIX,
    PH_CONTENT,
    PH_COMPLETE,
    PH_DRAIN,
    PH_LOAD
  } imu_phase_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  def_field;
    logic [4:0]  def_prefix_digits;
    logic [14:0] def_max_len;
    logic [7:0]  msg_byte;
    logic        msg_last;
  } imu_in_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  field_number;
    logic [7:0]  field_byte;
    logic [14:0] byte_offset;
    logic        field_end;
    logic [14:0] field_length;
    logic        msg_done;
    logic [2:0]  status;
  } imu_out_t;

  // Result of the next-field search.
  typedef struct packed {
    logic               found;
    logic [FieldAw-1:0] index;
  } imu_find_t;

endpackage
`default_nettype wire

>>> rtl/imu_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_in_if / imu_out_if
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
interface imu_in_if;
  import imu_pkg::*;
  logic    valid;
  logic    ready;
  imu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface imu_out_if;
  import imu_pkg::*;
  logic     valid;
  logic     ready;
  imu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/imu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module imu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output      logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/imu_field_find.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_field_find
// Finds the lowest present, non-empty field at or above a start field.
// ----------------------------------------------------------------------------
module imu_field_find (
  input  wire logic [imu_pkg::NumFields-1:0] present,
  input  wire logic [imu_pkg::NumFields-1:0] nonempty,
  input  wire logic [7:0]                    start,
  output      imu_pkg::imu_find_t            result
);
  import imu_pkg::*;

  logic [NumFields-1:0] cand;

  // Candidate k stands for field k+1.
  always_comb begin
    for (int k = 0; k < NumFields; k++) begin
      cand[k] = present[k] & nonempty[k] & ((k + 1) >= int'(start));
    end
  end

  // Priority encoder, lowest field wins.
  always_comb begin
    result.found = 1'b0;
    result.index = '0;
    for (int k = NumFields - 1; k >= 0; k--) begin
      if (cand[k]) begin
        result.found = 1'b1;
        result.index = FieldAw'(k);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/iso8583_message_unpacker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iso8583_message_unpacker_top
// Streams ISO 8583 messages with a 128-bit bitmap into per-field content bytes.
// ----------------------------------------------------------------------------
// Each request is a field definition write or one message byte. A byte that
// moves the parser on to a new field stalls the input: the next present field
// is found in the same cycle, but its definition is read from the definition
// RAM with registered read data, and no request is taken while that read is
// pending. Results wait in an output register, and the block keeps taking
// requests while a result is held there and the sink is taking it.
// ----------------------------------------------------------------------------
module iso8583_message_unpacker_top (
  input wire logic   clk,
  input wire logic   rst,
  imu_in_if.sink     msg_in,
  imu_out_if.source  res_out
);
  import imu_pkg::*;

  imu_phase_t           phase, phase_next;
  logic [NumFields-1:0] pb, pb_next;
  logic [NumFields-1:0] ne;
  logic [15:0]          cnt, cnt_next;
  logic [7:0]           cur, cur_next;
  logic [4:0]           dleft, dleft_next;
  logic [14:0]          acc, acc_next;
  logic [14:0]          cleft, cleft_next;
  logic [14:0]          maxl, maxl_next;
  logic                 err, err_next;
  logic                 rd_pend, rd_pend_next;
  logic                 out_valid;
  imu_out_t             out_data, res;
  logic                 has_res;

  logic                 accept;
  imu_in_t              d;
  logic                 def_ok;
  logic [2:0]           len_digits;
  logic [FieldAw-1:0]   def_k;
  logic [DefW-1:0]      rd_data;
  logic [7:0]           find_start;
  imu_find_t            found;
  logic                 rd_en;

  assign d       = msg_in.data;
  assign msg_in.ready = (!out_valid || res_out.ready) && !rd_pend;
  assign accept  = msg_in.valid && msg_in.ready;
  assign res_out.valid = out_valid;
  assign res_out.data  = out_data;

  // Validity of a definition write.
  always_comb begin
    priority if (d.def_max_len >= 15'd10000) len_digits = 3'd5;
    else if (d.def_max_len >= 15'd1000) len_digits = 3'd4;
    else if (d.def_max_len >= 15'd100) len_digits = 3'd3;
    else if (d.def_max_len >= 15'd10) len_digits = 3'd2;
    else len_digits = 3'd1;
    def_ok = (d.def_field >= 8'd2) && (int'(d.def_field) <= NumFields)
          && (int'(d.def_prefix_digits) <= MaxPrefixDigits)
          && (int'(d.def_max_len) <= MaxFieldLen)
          && !((d.def_prefix_digits != 5'd0) && (d.def_max_len != 15'd0)
               && (5'(len_digits) > d.def_prefix_digits));
  end
  assign def_k = FieldAw'(d.def_field - 8'd1);

  // Bitmap capture; the final bitmap byte is visible to the search at once.
  always_comb begin
    pb_next = pb;
    if (accept && d.opcode == OP_BYTE && phase == PH_BITMAP) begin
      for (int i = 0; i < 8; i++) begin
        pb_next[{cnt[3:0] - 4'd4, 3'(i)}] = d.msg_byte[7 - i];
      end
    end
  end

  // Search start: field 2 after the bitmap, otherwise the field after the current one.
  always_comb begin
    find_start = (phase == PH_BITMAP) ? 8'd2 : cur + 8'd1;
  end

  imu_field_find u_find (
    .present  (pb_next),
    .nonempty (ne),
    .start    (find_start),
    .result   (found)
  );

  imu_ram #(.Width(DefW), .Depth(NumFields)) u_defs (
    .clk     (clk),
    .wr_en   (accept && d.opcode == OP_DEFINE && def_ok),
    .wr_addr (def_k),
    .wr_data ({d.def_prefix_digits, d.def_max_len}),
    .rd_en   (rd_en),
    .rd_addr (found.index),
    .rd_data (rd_data)
  );

  // Per-byte parser step.
  always_comb begin
    logic        adv;
    logic        done;
    logic [2:0]  st;
    logic [18:0] prod;
    phase_next   = phase;
    cnt_next     = cnt;
    cur_next     = cur;
    dleft_next   = dleft;
    acc_next     = acc;
    cleft_next   = cleft;
    maxl_next    = maxl;
    err_next     = err;
    rd_pend_next = 1'b0;
    rd_en        = 1'b0;
    res          = '0;
    adv          = 1'b0;
    done         = 1'b0;
    st           = ST_OK;
    prod         = '0;
    has_res      = 1'b0;

    if (rd_pend) begin
      // Definition of the newly selected field has arrived.
      acc_next   = (rd_data[19:15] != 5'd0) ? 15'd0 : rd_data[14:0];
      cleft_next = rd_data[14:0];
      dleft_next = rd_data[19:15];
      maxl_next  = rd_data[14:0];
      phase_next = (rd_data[19:15] != 5'd0) ? PH_PREFIX : PH_CONTENT;
    end else if (accept && d.opcode == OP_DEFINE) begin
      // A rewrite of the field under way changes its length limit.
      if (def_ok && (d.def_field == cur)) begin
        maxl_next = d.def_max_len;
      end
    end else if (accept) begin
      if (cnt != 16'hFFFF) begin
        cnt_next = cnt + 16'd1;
      end
      unique case (phase)
        PH_MTI: begin
          res.data_valid   = 1'b1;
          res.field_byte   = d.msg_byte;
          res.byte_offset  = {13'd0, cnt[1:0]};
          res.field_length = 15'd4;
          if (cnt >= 16'd3) begin
            res.field_end = 1'b1;
            phase_next    = PH_BITMAP;
          end
        end
        PH_BITMAP: begin
          if (cnt >= 16'd19) begin
            adv = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (d.msg_byte < 8'h30 || d.msg_byte > 8'h39) begin
            done = 1'b1; st = ST_BAD_DIGIT; err_next = 1'b1; phase_next = PH_DRAIN;
          end else begin
            prod = 19'(acc) * 19'd10 + 19'(d.msg_byte - 8'h30);
            acc_next = (prod > 19'(MaxFieldLen + 1)) ? 15'(MaxFieldLen + 1) : prod[14:0];
            if (dleft != 5'd0) begin
              dleft_next = dleft - 5'd1;
            end
            if (dleft <= 5'd1) begin
              if (acc_next > maxl) begin
                done = 1'b1; st = ST_OVER_LEN; err_next = 1'b1; phase_next = PH_DRAIN;
              end else if (acc_next == 15'd0) begin
                adv = 1'b1;
              end else begin
                cleft_next = acc_next;
                phase_next = PH_CONTENT;
              end
            end
          end
        end
        PH_CONTENT: begin
          res.data_valid   = 1'b1;
          res.field_number = cur;
          res.field_byte   = d.msg_byte;
          res.field_length = acc;
          res.byte_offset  = acc - cleft;
          if (cleft != 15'd0) begin
            cleft_next = cleft - 15'd1;
          end
          if (cleft <= 15'd1) begin
            res.field_end = 1'b1;
            adv           = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Move on to the next present field, or finish the field list.
      if (adv) begin
        if (found.found) begin
          cur_next     = 8'(found.index) + 8'd1;
          acc_next     = 15'd0;
          phase_next   = PH_LOAD;
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
        end else begin
          phase_next = PH_COMPLETE;
        end
      end

      if (phase_next == PH_COMPLETE && cnt >= 16'(HeaderBytes) && !done) begin
        done       = 1'b1;
        st         = ST_OK;
        phase_next = PH_DRAIN;
      end

      // The last byte always closes the message.
      if (d.msg_last) begin
        if (!done && phase_next != PH_DRAIN) begin
          done = 1'b1;
          st   = (cnt < 16'(HeaderBytes)) ? ST_SHORT : ST_TRUNCATED;
        end
        phase_next   = PH_MTI;
        cnt_next     = '0;
        cur_next     = '0;
        dleft_next   = '0;
        acc_next     = '0;
        cleft_next   = '0;
        err_next     = 1'b0;
        rd_pend_next = 1'b0;
      end

      res.msg_done = done;
      res.status   = st;
      has_res      = res.data_valid || done;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_MTI;
      pb      <= '0;
      cnt     <= '0;
      cur     <= '0;
      dleft   <= '0;
      acc     <= '0;
      cleft   <= '0;
      maxl    <= '0;
      err     <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      phase   <= phase_next;
      pb      <= (accept && d.opcode == OP_BYTE && d.msg_last) ? '0 : pb_next;
      cnt     <= cnt_next;
      cur     <= cur_next;
      dleft   <= dleft_next;
      acc     <= acc_next;
      cleft   <= cleft_next;
      maxl    <= maxl_next;
      err     <= err_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Non-empty mask, one flag per field.
  always_ff @(posedge clk) begin
    if (rst) begin
      ne <= '0;
    end else if (accept && d.opcode == OP_DEFINE && def_ok) begin
      ne[def_k] <= (d.def_prefix_digits != 5'd0) || (d.def_max_len != 15'd0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && has_res) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      out_data <= res;
    end
  end

  // A pending definition read always stalls the input.
  a_load_stall : assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !msg_in.ready)
    else $error("request taken during definition read");

  a_load_once : assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> !rd_pend)
    else $error("definition read lasted more than one cycle");

  a_status_done : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.msg_done) |-> (out_data.status == ST_OK))
    else $error("status without message end");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.ready) |=> ($stable(out_data) && out_valid))
    else $error("held result was overwritten");

endmodule
`default_nettype wire

>>> test/tb_iso8583_message_unpacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso8583_message_unpacker_top
// Self-checking testbench of the ISO 8583 message unpacker. Field definitions
// and message bytes are sent as requests. A predictor inside the testbench
// works out the expected field bytes and completion results. A checker
// compares each result request with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_iso8583_message_unpacker_top;
  import imu_pkg::*;

  localparam int FieldPh    = 0;
  localparam int FieldBmap  = 1;
  localparam int FieldPre   = 2;
  localparam int FieldBody  = 3;
  localparam int FieldDone  = 4;
  localparam int FieldDrain = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imu_in_if  msg_in ();
  imu_out_if res_out ();

  iso8583_message_unpacker_top dut (
    .clk     (clk),
    .rst     (rst),
    .msg_in  (msg_in.sink),
    .res_out (res_out.source)
  );

  always #5 clk = ~clk;

  // Idling controls shared by the sender and the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int errors = 0;

  imu_out_t expected_results[$];

  // Predictor state.
  logic [19:0]  pr_defs [1:128];
  logic [128:1] pr_nonempty;
  logic [128:1] pr_bitmap;
  int           pr_phase;
  int           pr_count;
  int           pr_field;
  int           pr_digits;
  int           pr_acc;
  int           pr_left;

  function automatic int digit_count(int v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // Moves to the first present, non-empty field at or above f.
  task automatic seek_field(int f);
    while (f <= NumFields) begin
      if (pr_bitmap[f] && pr_nonempty[f]) begin
        pr_field = f;
        pr_acc = 0;
        if (pr_defs[f][19:15] != 0) begin
          pr_digits = int'(pr_defs[f][19:15]);
          pr_phase = FieldPre;
        end else begin
          pr_acc = int'(pr_defs[f][14:0]);
          pr_left = pr_acc;
          pr_phase = FieldBody;
        end
        return;
      end
      f++;
    end
    pr_phase = FieldDone;
  endtask

  task automatic restart_message();
    pr_bitmap = '0;
    pr_phase = FieldPh;
    pr_count = 0;
    pr_field = 0;
    pr_digits = 0;
    pr_acc = 0;
    pr_left = 0;
  endtask

  task automatic clear_predictor();
    for (int i = 1; i <= 128; i++) pr_defs[i] = '0;
    pr_nonempty = '0;
    restart_message();
  endtask

  // Works out the result, if any, of one accepted request.
  task automatic predict_request(imu_in_t r);
    imu_out_t o;
    int cnt, b, maxl;
    o = '0;
    if (r.opcode == OP_DEFINE) begin
      if (r.def_field < 2 || r.def_field > NumFields) return;
      if (r.def_prefix_digits > MaxPrefixDigits || r.def_max_len > MaxFieldLen) return;
      if (r.def_prefix_digits > 0 && r.def_max_len > 0 &&
          digit_count(int'(r.def_max_len)) > r.def_prefix_digits) return;
      pr_defs[r.def_field] = {r.def_prefix_digits, r.def_max_len};
      pr_nonempty[r.def_field] = (r.def_prefix_digits != 0) || (r.def_max_len != 0);
      return;
    end
    cnt = pr_count;
    b = int'(r.msg_byte);
    if (pr_count < 65535) pr_count++;
    case (pr_phase)
      FieldPh: begin
        o.data_valid = 1'b1;
        o.field_byte = 8'(b);
        o.byte_offset = 15'(cnt & 3);
        o.field_length = 15'd4;
        if (cnt >= 3) begin
          o.field_end = 1'b1;
          pr_phase = FieldBmap;
        end
      end
      FieldBmap: begin
        for (int k = 0; k < 8; k++) pr_bitmap[(cnt - 4) * 8 + k + 1] = b[7 - k];
        if (cnt >= 19) seek_field(2);
      end
      FieldPre: begin
        if (b < 8'h30 || b > 8'h39) begin
          o.msg_done = 1'b1;
          o.status = ST_BAD_DIGIT;
          pr_phase = FieldDrain;
        end else begin
          pr_acc = pr_acc * 10 + (b - 8'h30);
          if (pr_acc > MaxFieldLen + 1) pr_acc = MaxFieldLen + 1;
          if (pr_digits > 0) pr_digits--;
          if (pr_digits == 0) begin
            maxl = int'(pr_defs[pr_field][14:0]);
            if (pr_acc > maxl) begin
              o.msg_done = 1'b1;
              o.status = ST_OVER_LEN;
              pr_phase = FieldDrain;
            end else if (pr_acc == 0) begin
              seek_field(pr_field + 1);
            end else begin
              pr_left = pr_acc;
              pr_phase = FieldBody;
            end
          end
        end
      end
      FieldBody: begin
        o.data_valid = 1'b1;
        o.field_number = 8'(pr_field);
        o.field_byte = 8'(b);
        o.field_length = 15'(pr_acc);
        o.byte_offset = 15'(pr_acc - pr_left);
        if (pr_left > 0) pr_left--;
        if (pr_left == 0) begin
          o.field_end = 1'b1;
          seek_field(pr_field + 1);
        end
      end
      default: ;
    endcase
    if (pr_phase == FieldDone && cnt >= HeaderBytes && !o.msg_done) begin
      o.msg_done = 1'b1;
      o.status = ST_OK;
      pr_phase = FieldDrain;
    end
    if (r.msg_last) begin
      if (!o.msg_done && pr_phase != FieldDrain) begin
        o.msg_done = 1'b1;
        o.status = (cnt < HeaderBytes) ? ST_SHORT : ST_TRUNCATED;
      end
      restart_message();
    end
    if (o.data_valid || o.msg_done) expected_results.push_back(o);
  endtask

  // Sends one request and predicts its result once it is accepted.
  // Ready is sampled at the falling edge, where it holds the value that the
  // next rising edge sees.
  task automatic send_request(imu_in_t r);
    logic ok;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      msg_in.valid <= 1'b0;
      @(posedge clk);
    end
    msg_in.valid <= 1'b1;
    msg_in.data  <= r;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = msg_in.ready;
      @(posedge clk);
    end
    predict_request(r);
  endtask

  task automatic send_define(int f, int pre, int len);
    imu_in_t r;
    r = '0;
    r.opcode = OP_DEFINE;
    r.def_field = 8'(f);
    r.def_prefix_digits = 5'(pre);
    r.def_max_len = 15'(len);
    r.msg_byte = 8'($urandom);
    r.msg_last = 1'($urandom_range(1));
    send_request(r);
  endtask

  task automatic send_byte(int b, bit last);
    imu_in_t r;
    r = imu_in_t'(38'({$urandom, $urandom}));
    r.opcode = OP_BYTE;
    r.msg_byte = 8'(b);
    r.msg_last = last;
    send_request(r);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    msg_in.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    while (n < 10) begin
      @(posedge clk);
      n++;
    end
  endtask

  // A whole message: type, bitmap from the given set, fields, optional tail.
  task automatic send_message(logic [128:1] bm, int bad_pct, int trunc_pct);
    int nbytes, len, pre, stop, sent;
    logic [7:0] q[$];
    for (int i = 0; i < 4; i++) q.push_back(8'($urandom_range(8'h30, 8'h39)));
    for (int i = 0; i < 16; i++)
      for (int k = 0; k < 8; k++) q.push_back(8'h00);
    q = q[0:3];
    for (int i = 0; i < 16; i++) q.push_back(bm[i * 8 + 1 +: 8] == 0 ? 8'h00 :
      {bm[i*8+1], bm[i*8+2], bm[i*8+3], bm[i*8+4], bm[i*8+5], bm[i*8+6],
       bm[i*8+7], bm[i*8+8]});
    for (int f = 2; f <= 128; f++) begin
      if (!bm[f]) continue;
      pre = int'(pr_defs[f][19:15]);
      len = int'(pr_defs[f][14:0]);
      if (pre != 0) begin
        // Variable fields are kept short so that messages stay small.
        len = (len == 0) ? 0 : $urandom_range(len > 12 ? 12 : len);
        if ($urandom_range(99) < bad_pct) len = len + $urandom_range(1, 3);
        for (int d = pre - 1; d >= 0; d--) begin
          int p;
          p = 1;
          for (int j = 0; j < d; j++) p = p * 10;
          q.push_back(8'(8'h30 + (len / p) % 10));
        end
        if ($urandom_range(99) < bad_pct)
          q[q.size() - 1] = 8'($urandom_range(8'h3a, 8'hff));
      end
      for (int i = 0; i < len; i++) q.push_back(8'($urandom));
    end
    nbytes = q.size() + $urandom_range(2);
    for (int i = q.size(); i < nbytes; i++) q.push_back(8'($urandom));
    stop = q.size();
    if ($urandom_range(99) < trunc_pct) stop = $urandom_range(1, q.size());
    for (sent = 0; sent < stop; sent++) send_byte(int'(q[sent]), sent == stop - 1);
  endtask

  function automatic logic [128:1] random_bitmap();
    logic [128:1] bm;
    bm = '0;
    for (int i = 0; i < 4; i++) bm[$urandom_range(1, 128)] = 1'b1;
    if ($urandom_range(3) == 0) bm[1] = 1'b1;
    return bm;
  endfunction

  task automatic test_definitions();
    send_define(0, 1, 5);
    send_define(1, 2, 5);
    send_define(129, 1, 5);
    send_define(255, 31, 32767);
    send_define(2, 21, 5);
    send_define(3, 1, 30001);
    send_define(4, 1, 10);
    send_define(2, 0, 3);
    send_define(3, 2, 20);
    send_define(5, 0, 0);
    send_define(6, 20, 30000);
    send_define(128, 1, 1);
    send_define(64, 5, 30000);
    send_define(7, 1, 0);
    wait_drained();
  endtask

  task automatic test_directed_messages();
    logic [128:1] bm;
    bm = '0;
    bm[1] = 1'b1; bm[2] = 1'b1; bm[3] = 1'b1; bm[5] = 1'b1; bm[7] = 1'b1;
    bm[128] = 1'b1;
    send_message(bm, 0, 0);
    // Short message and header-only message.
    for (int i = 0; i < 6; i++) send_byte(8'hff, i == 5);
    send_message('0, 0, 0);
    send_message(bm, 100, 0);
    send_message(bm, 0, 100);
    wait_drained();
  endtask

  task automatic test_random(int n_msgs);
    for (int m = 0; m < n_msgs; m++) begin
      case ($urandom_range(9))
        0: send_define($urandom_range(255), $urandom_range(31), $urandom_range(40));
        1: send_byte($urandom, $urandom_range(1));
        default: send_message(random_bitmap(), 10, 10);
      endcase
    end
  endtask

  task automatic test_random_defs();
    for (int i = 0; i < 12; i++) begin
      int pre;
      pre = $urandom_range(4);
      send_define($urandom_range(2, 128), pre, pre == 0 ? $urandom_range(6) :
                  $urandom_range(9 < 10 ** pre ? 9 : 9));
    end
    send_define(129, 0, 32767);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 200;
    send_idle_pct = 0;
    send_message(random_bitmap(), 0, 0);
    send_message(random_bitmap(), 0, 0);
    wait_drained();
  endtask

  // Long receiver hold-off, counted down one cycle at a time.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Receiver stalls, redrawn at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: a result with valid and ready high at the falling edge
  // is taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && res_out.valid && res_out.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_out.data);
        errors++;
      end else begin
        if (res_out.data !== expected_results[0]) begin
          $display("%0t: expected %h, actual %h", $time, expected_results[0],
                   res_out.data);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    msg_in.valid = 1'b0;
    msg_in.data = '0;
    res_out.ready = 1'b0;
    clear_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_definitions();
    test_directed_messages();
    test_random_defs();
    test_random(6);
    send_idle_pct = 80;
    test_random(4);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    test_random(4);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(4);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    test_backpressure();
    wait_drained();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
